@@ hdl/indexed_binary_heap_unit_macros.svh @@
// Assertion macros for the port checker of the indexed binary heap unit.
`ifndef INDEXED_BINARY_HEAP_UNIT_MACROS_SVH
`define INDEXED_BINARY_HEAP_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define IBH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed binary heap check failed");

// Next-cycle implication, switched off while reset is high.
`define IBH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed binary heap check failed");

`endif

@@ hdl/ibh_pkg.sv @@
// Types and constants of the indexed binary heap unit.
package ibh_pkg;

   localparam int SLOT_FIELD_W  = 10;
   localparam int ID_FIELD_W    = 10;
   localparam int KEY_FIELD_W   = 32;
   localparam int COUNT_FIELD_W = 11;
   localparam int ID_FIELD_MAX  = (1 << ID_FIELD_W) - 1;

   typedef logic [1:0] mode_type;

   localparam mode_type ORDER_MIN = 2'd1;
   localparam mode_type ORDER_MAX = 2'd2;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_CHANGE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                        cmd;
      logic [SLOT_FIELD_W-1:0]        slot_index;
      logic [ID_FIELD_W-1:0]          item_id;
      logic signed [KEY_FIELD_W-1:0]  item_key;
   } req_payload_type;

   typedef struct packed {
      status_type                     status;
      logic [SLOT_FIELD_W-1:0]        final_slot;
      logic [COUNT_FIELD_W-1:0]       heap_count;
      logic [ID_FIELD_W-1:0]          top_item;
   } rsp_payload_type;

endpackage

@@ hdl/indexed_binary_heap_unit.sv @@
// Indexed binary heap: heap of item ids and key table in memories, sifted by a sequencer.
//
//   Channel  Direction  Handshake               Word
//   req      in         req_valid / req_ready   req_payload_type (command, slot, id, key)
//   rsp      out        rsp_valid / rsp_ready   rsp_payload_type (status, slot, size, top)
//   csr      in         csr_valid / csr_ready   order mode, always ready
//
// One word at a time: an insert or a change compares at most log2 of CAPACITY levels,
// each a heap read then a key read. A rejected word goes straight to its result.
// An ID_COUNT below 1024 that is not a power of two adds the state S_MOD, which reduces
// the id to a key table index by a reciprocal multiply.
// Synchronous reset clears the size and control; the memories are not cleared.
// A finished result waits in the output register; the next word stalls only at its own.
module indexed_binary_heap_unit
   import ibh_pkg::*;
#(
   parameter int CAPACITY  = 1024,
   parameter int ID_COUNT  = 1024,
   parameter int KEY_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  mode_type        csr_wdata
);

   localparam int SW        = $clog2(CAPACITY);
   localparam int NW        = $clog2(CAPACITY + 1);
   localparam int KIW       = $clog2(ID_COUNT);
   localparam int KXW       = (KIW > ID_FIELD_W) ? KIW : ID_FIELD_W;
   localparam int MOD_STEPS = (ID_COUNT > ID_FIELD_MAX) ? 0 :
                              (((ID_COUNT & (ID_COUNT - 1)) == 0) ? 0 : 2);
   localparam int RED_SHIFT = 2 * ID_FIELD_W;
   localparam int RED_RECIP = ((1 << RED_SHIFT) + ID_COUNT - 1) / ID_COUNT;
   localparam int EW        = KIW + ID_FIELD_W;

   typedef struct packed {
      logic [KIW-1:0]        kidx;
      logic [ID_FIELD_W-1:0] id;
   } entry_type;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_MOD     = 11'b000_0000_0010,
      S_KEYW    = 11'b000_0000_0100,
      S_CHG_KEY = 11'b000_0000_1000,
      S_CHG_CMP = 11'b000_0001_0000,
      S_UP_KEY  = 11'b000_0010_0000,
      S_UP_CMP  = 11'b000_0100_0000,
      S_DN_KEY  = 11'b000_1000_0000,
      S_DN_CMP  = 11'b001_0000_0000,
      S_PUT     = 11'b010_0000_0000,
      S_DONE    = 11'b100_0000_0000
   } state_type;

   // Control registers
   state_type       state_ff, state_in;
   mode_type        order_ff, order_in;
   logic [NW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Working registers of the current word
   cmd_type                      cmd_ff, cmd_in;
   logic [SW-1:0]                slot_ff, slot_in;
   logic [SW-1:0]                lastp_ff, lastp_in;
   logic [ID_FIELD_W-1:0]        id_ff, id_in;
   logic [KXW-1:0]               rem_ff, rem_in;
   logic                         modk_ff, modk_in;
   logic [ID_FIELD_W-1:0]        quo_ff, quo_in;
   logic signed [KEY_WIDTH-1:0]  key_ff, key_in;
   status_type                   status_ff, status_in;
   logic [ID_FIELD_W-1:0]        top_ff, top_in;
   rsp_payload_type              rsp_ff, rsp_in;

   // Heap memory: one write port, two read ports, registered read data
   logic [EW-1:0]   heap_mem_ff [CAPACITY];
   logic            hwe, hre;
   logic [SW-1:0]   hwaddr, hra, hrb;
   entry_type       hwdata;
   entry_type       hrd_a_ff, hrd_b_ff;

   // Key memory: one write port, two read ports, registered read data
   logic signed [KEY_WIDTH-1:0] key_mem_ff [ID_COUNT];
   logic                        kwe, kre;
   logic [KIW-1:0]              kra, krb;
   logic signed [KEY_WIDTH-1:0] krd_a_ff, krd_b_ff;

   logic [KIW-1:0]  kidx;
   entry_type       new_entry;
   logic [31:0]     red_prod;
   logic [31:0]     red_back;
   logic [SW-1:0]   parent_s;
   logic            pick_left, stop_left, stop_right;
   logic [SW-1:0]   c_slot;
   entry_type       c_entry;

   function automatic logic before_f(input mode_type m,
                                     input logic signed [KEY_WIDTH-1:0] ka,
                                     input logic signed [KEY_WIDTH-1:0] kb);
      logic r;
      case (m)
         ORDER_MIN: r = (ka <= kb);
         ORDER_MAX: r = (ka >= kb);
         default:   r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [SW-1:0] parent_f(input logic [SW-1:0] x);
      return (x - SW'(1)) >> 1;
   endfunction

   function automatic logic [SW-1:0] left_f(input logic [SW-1:0] x);
      logic [SW:0] w;
      w = {x, 1'b1};
      return w[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] right_f(input logic [SW-1:0] x);
      logic [SW:0] w;
      w = {x, 1'b1} + (SW+1)'(1);
      return w[SW-1:0];
   endfunction

   assign kidx      = rem_ff[KIW-1:0];
   assign new_entry = '{kidx: kidx, id: id_ff};
   assign red_prod  = 32'(rem_ff) * 32'(RED_RECIP);
   assign red_back  = 32'(quo_ff) * 32'(ID_COUNT);
   assign parent_s  = parent_f(slot_ff);

   // Choice between the two children and whether the new item stays above each.
   assign pick_left  = before_f(order_ff, krd_a_ff, krd_b_ff);
   assign stop_left  = before_f(order_ff, key_ff, krd_a_ff);
   assign stop_right = before_f(order_ff, key_ff, krd_b_ff);
   assign c_slot     = pick_left ? left_f(slot_ff) : right_f(slot_ff);
   assign c_entry    = pick_left ? hrd_a_ff : hrd_b_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      order_in     = csr_valid ? csr_wdata : order_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      lastp_in     = lastp_ff;
      id_in        = id_ff;
      rem_in       = rem_ff;
      modk_in      = modk_ff;
      quo_in       = quo_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      hwe          = 1'b0;
      hwaddr       = slot_ff;
      hwdata       = new_entry;
      hre          = 1'b0;
      hra          = slot_ff;
      hrb          = slot_ff;
      kwe          = 1'b0;
      kre          = 1'b0;
      kra          = hrd_a_ff.kidx;
      krb          = hrd_b_ff.kidx;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_data.cmd;
               id_in   = req_data.item_id;
               rem_in  = KXW'(32'(req_data.item_id));
               modk_in = 1'b0;
               key_in  = KEY_WIDTH'(64'($signed(req_data.item_key)));
               if (req_data.cmd == CMD_INSERT) begin
                  slot_in = SW'(32'(count_ff));
                  if (32'(count_ff) >= 32'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     status_in = STATUS_DONE;
                     state_in  = (MOD_STEPS > 0) ? S_MOD : S_KEYW;
                  end
               end else begin
                  slot_in = SW'(32'(req_data.slot_index));
                  if (32'(req_data.slot_index) >= 32'(count_ff)) begin
                     status_in = STATUS_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     status_in = STATUS_DONE;
                     state_in  = (MOD_STEPS > 0) ? S_MOD : S_KEYW;
                  end
               end
            end
         end

         // The id modulo ID_COUNT by a reciprocal multiply: the quotient first, then the
         // remainder.
         S_MOD: begin
            if (!modk_ff) begin
               quo_in  = red_prod[RED_SHIFT +: ID_FIELD_W];
               modk_in = 1'b1;
            end else begin
               rem_in   = KXW'(32'(rem_ff) - red_back);
               state_in = S_KEYW;
            end
         end

         S_KEYW: begin
            kwe      = 1'b1;
            lastp_in = SW'((count_ff - NW'(1)) >> 1);
            if (cmd_ff == CMD_INSERT) begin
               count_in = count_ff + NW'(1);
               if (slot_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  hre      = 1'b1;
                  hra      = parent_s;
                  state_in = S_UP_KEY;
               end
            end else begin
               hre      = 1'b1;
               hra      = slot_ff;
               state_in = S_CHG_KEY;
            end
         end

         S_CHG_KEY: begin
            kre      = 1'b1;
            state_in = S_CHG_CMP;
         end

         // The new item goes up if it belongs before the item it replaces.
         S_CHG_CMP: begin
            if (before_f(order_ff, key_ff, krd_a_ff)) begin
               if (slot_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  hre      = 1'b1;
                  hra      = parent_s;
                  state_in = S_UP_KEY;
               end
            end else if (slot_ff < lastp_ff || (slot_ff == lastp_ff && !count_ff[0])) begin
               hre      = 1'b1;
               hra      = left_f(slot_ff);
               hrb      = right_f(slot_ff);
               state_in = S_DN_KEY;
            end else begin
               state_in = S_PUT;
            end
         end

         S_UP_KEY: begin
            kre      = 1'b1;
            state_in = S_UP_CMP;
         end

         S_UP_CMP: begin
            if (before_f(order_ff, krd_a_ff, key_ff)) begin
               state_in = S_PUT;
            end else begin
               hwe     = 1'b1;
               hwdata  = hrd_a_ff;
               slot_in = parent_s;
               if (parent_s == '0) begin
                  state_in = S_PUT;
               end else begin
                  hre      = 1'b1;
                  hra      = parent_f(parent_s);
                  state_in = S_UP_KEY;
               end
            end
         end

         S_DN_KEY: begin
            kre      = 1'b1;
            state_in = S_DN_CMP;
         end

         S_DN_CMP: begin
            if (slot_ff < lastp_ff) begin
               if (pick_left ? stop_left : stop_right) begin
                  state_in = S_PUT;
               end else begin
                  hwe     = 1'b1;
                  hwdata  = c_entry;
                  slot_in = c_slot;
                  if (c_slot < lastp_ff || (c_slot == lastp_ff && !count_ff[0])) begin
                     hre      = 1'b1;
                     hra      = left_f(c_slot);
                     hrb      = right_f(c_slot);
                     state_in = S_DN_KEY;
                  end else begin
                     state_in = S_PUT;
                  end
               end
            end else begin
               // Only a left child exists; it is a leaf.
               if (!before_f(order_ff, krd_a_ff, key_ff)) begin
                  hwe     = 1'b1;
                  hwdata  = hrd_a_ff;
                  slot_in = left_f(slot_ff);
               end
               state_in = S_PUT;
            end
         end

         S_PUT: begin
            hwe      = 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = status_ff;
               rsp_in.final_slot = (status_ff == STATUS_DONE) ?
                                   SLOT_FIELD_W'(32'(slot_ff)) : '0;
               rsp_in.heap_count = COUNT_FIELD_W'(32'(count_ff));
               rsp_in.top_item   = (count_ff != '0) ? top_ff : '0;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The id at slot zero is tracked from the write port, so no read is needed for it.
   always_comb begin
      top_in = top_ff;
      if (hwe && hwaddr == '0) begin
         top_in = hwdata.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         order_ff     <= ORDER_MIN;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      slot_ff   <= slot_in;
      lastp_ff  <= lastp_in;
      id_ff     <= id_in;
      rem_ff    <= rem_in;
      modk_ff   <= modk_in;
      quo_ff    <= quo_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      top_ff    <= top_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (hwe) begin
         heap_mem_ff[hwaddr] <= hwdata;
      end
      if (hre) begin
         hrd_a_ff <= heap_mem_ff[hra];
         hrd_b_ff <= heap_mem_ff[hrb];
      end
   end

   always_ff @(posedge clock) begin
      if (kwe) begin
         key_mem_ff[kidx] <= key_ff;
      end
      if (kre) begin
         krd_a_ff <= key_mem_ff[kra];
         krd_b_ff <= key_mem_ff[krb];
      end
   end

endmodule

@@ hdl/ibh_checker.sv @@
// Port checker of the indexed binary heap unit and its binding.
`include "indexed_binary_heap_unit_macros.svh"

module ibh_checker
   import ibh_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A result waiting to be taken keeps its word.
   `IBH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Words are worked on one at a time, so the input closes after each accepted word.
   `IBH_ASSERT_NEXT(a_one_word, clock, reset, req_valid && req_ready, !req_ready)

   // A rejected word reports slot zero.
   `IBH_ASSERT_IMP(a_error_slot, clock, reset, rsp_valid && rsp_data.status != STATUS_DONE, rsp_data.final_slot == '0)

   // A completed word always leaves at least one item in the heap.
   `IBH_ASSERT_IMP(a_done_count, clock, reset, rsp_valid && rsp_data.status == STATUS_DONE, rsp_data.heap_count != '0)

   // An empty heap reports top id zero.
   `IBH_ASSERT_IMP(a_empty_top, clock, reset, rsp_valid && rsp_data.heap_count == '0, rsp_data.top_item == '0)

endmodule

bind indexed_binary_heap_unit ibh_checker u_ibh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ verif/heap_checker.sv @@
// Checker for the indexed binary heap unit: predicts every result word and compares it.
`timescale 1ns / 100ps

module heap_checker
   import ibh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  mode_type        csr_wdata,
   output int              fail_count,
   output int              pending_count,
   output int              checked_count,
   output int              full_count,
   output int              range_count
);

   localparam int HEAP_DEPTH = 1024;

   logic [ID_FIELD_W-1:0]         heap_ids [0:HEAP_DEPTH-1];
   logic signed [KEY_FIELD_W-1:0] id_keys  [0:ID_FIELD_MAX];
   int                            heap_size;
   mode_type                      order_sel;
   rsp_payload_type               predicted_rsp [$];
   rsp_payload_type               want;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      full_count    = 0;
      range_count   = 0;
      heap_size     = 0;
      order_sel     = ORDER_MIN;
      for (int i = 0; i < HEAP_DEPTH; i++) begin
         heap_ids[i] = '0;
         id_keys[i]  = '0;
      end
   end

   // True when item a belongs above item b; ties count as already in order.
   function automatic bit goes_first(logic [ID_FIELD_W-1:0] a, logic [ID_FIELD_W-1:0] b);
      case (order_sel)
         ORDER_MIN: return id_keys[a] <= id_keys[b];
         ORDER_MAX: return id_keys[a] >= id_keys[b];
         default:   return 1'b0;
      endcase
   endfunction

   function automatic int climb(int s, logic [ID_FIELD_W-1:0] id);
      int p;
      while (s > 0) begin
         p = (s - 1) / 2;
         if (goes_first(heap_ids[p], id))
            break;
         heap_ids[s] = heap_ids[p];
         s = p;
      end
      heap_ids[s] = id;
      return s;
   endfunction

   function automatic int sink(int s, logic [ID_FIELD_W-1:0] id);
      int last_parent;
      int lc;
      int c;
      last_parent = (heap_size - 1) / 2;
      while (s < last_parent) begin
         lc = 2 * s + 1;
         c  = goes_first(heap_ids[lc], heap_ids[lc + 1]) ? lc : lc + 1;
         if (goes_first(id, heap_ids[c])) begin
            heap_ids[s] = id;
            return s;
         end
         heap_ids[s] = heap_ids[c];
         s = c;
      end
      // A last parent with only a left child is handled on its own.
      if (s == last_parent && heap_size % 2 == 0) begin
         lc = 2 * s + 1;
         if (!goes_first(heap_ids[lc], id)) begin
            heap_ids[s] = heap_ids[lc];
            s = lc;
         end
      end
      heap_ids[s] = id;
      return s;
   endfunction

   function automatic rsp_payload_type apply_word(req_payload_type w);
      rsp_payload_type r;
      int              slot;
      r        = '0;
      r.status = STATUS_DONE;
      slot     = int'(w.slot_index);
      if (w.cmd == CMD_INSERT) begin
         if (heap_size >= HEAP_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            id_keys[w.item_id] = w.item_key;
            heap_size++;
            r.final_slot = SLOT_FIELD_W'(climb(heap_size - 1, w.item_id));
         end
      end else if (slot >= heap_size) begin
         r.status = STATUS_RANGE;
      end else begin
         // The new key goes in first, then the new item is weighed against the old one.
         id_keys[w.item_id] = w.item_key;
         if (goes_first(w.item_id, heap_ids[slot]))
            r.final_slot = SLOT_FIELD_W'(climb(slot, w.item_id));
         else
            r.final_slot = SLOT_FIELD_W'(sink(slot, w.item_id));
      end
      r.heap_count = COUNT_FIELD_W'(heap_size);
      r.top_item   = (heap_size > 0) ? heap_ids[0] : '0;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         heap_size = 0;
         order_sel = ORDER_MIN;
         predicted_rsp.delete();
      end else begin
         if (csr_valid && csr_ready)
            order_sel = csr_wdata;
         if (req_valid && req_ready)
            predicted_rsp.push_back(apply_word(req_data));
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               report_mismatch($sformatf("result word with none outstanding (status %0d)",
                                         rsp_data.status));
            end else begin
               want = predicted_rsp.pop_front();
               checked_count++;
               if (want.status == STATUS_FULL)
                  full_count++;
               if (want.status == STATUS_RANGE)
                  range_count++;
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.final_slot !== want.final_slot)
                  report_mismatch($sformatf("final_slot %0d, expected %0d",
                                            rsp_data.final_slot, want.final_slot));
               if (rsp_data.heap_count !== want.heap_count)
                  report_mismatch($sformatf("heap_count %0d, expected %0d",
                                            rsp_data.heap_count, want.heap_count));
               if (rsp_data.top_item !== want.top_item)
                  report_mismatch($sformatf("top_item %0d, expected %0d",
                                            rsp_data.top_item, want.top_item));
            end
         end
      end
      pending_count = predicted_rsp.size();
   end

endmodule

@@ verif/tb.sv @@
// Testbench top for the indexed binary heap unit: stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb;
   import ibh_pkg::*;

   localparam int       HEAP_DEPTH   = 1024;
   localparam int       PHASE_WORDS  = 210;
   localparam int       PHASE_COUNT  = 8;
   localparam int       HOLD_CYCLES  = 400;
   localparam int       CYCLE_LIMIT  = 600000;
   localparam mode_type ORDER_NONE   = 2'd0;
   localparam mode_type ORDER_NONE_B = 2'd3;

   localparam logic signed [KEY_FIELD_W-1:0] KEY_TOP = 32'sh7fffffff;
   localparam logic signed [KEY_FIELD_W-1:0] KEY_BOT = 32'sh80000000;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   mode_type        csr_wdata;

   int fail_count;
   int pending_count;
   int checked_count;
   int full_count;
   int range_count;
   int heap_fill;
   int gap_pct;
   int stall_pct;
   int cycle_count;
   bit hold_armed;
   bit hold_done;

   // Idling per phase as a percentage: none, sender, receiver, both.
   int       gap_plan   [4] = '{0, 74, 0, 31};
   int       stall_plan [4] = '{0, 0, 74, 31};
   mode_type mode_plan  [PHASE_COUNT] = '{ORDER_MIN, ORDER_MAX, ORDER_NONE, ORDER_MIN,
                                          ORDER_MAX, ORDER_NONE_B, ORDER_MAX, ORDER_MIN};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   indexed_binary_heap_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   heap_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .full_count    (full_count),
      .range_count   (range_count)
   );

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending_count);
      $display("== FAIL ==");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off so that the block backs up.
   initial begin
      int held;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic signed [KEY_FIELD_W-1:0] pick_key();
      case ($urandom_range(9))
         0, 1, 2: return $signed($urandom_range(4)) - 2;
         3:       return $urandom_range(1) ? KEY_TOP : KEY_BOT;
         default: return $urandom;
      endcase
   endfunction

   // Mostly valid slots, with the ends of the heap and the odd slot past its size.
   function automatic req_payload_type random_word();
      req_payload_type w;
      int unsigned     roll;
      w.item_id    = ID_FIELD_W'($urandom_range(ID_FIELD_MAX));
      w.item_key   = pick_key();
      w.slot_index = SLOT_FIELD_W'($urandom_range(HEAP_DEPTH - 1));
      roll         = $urandom_range(99);
      if ((heap_fill < HEAP_DEPTH) ? (roll < 70) : (roll < 15)) begin
         w.cmd = CMD_INSERT;
      end else begin
         w.cmd = CMD_CHANGE;
         roll  = $urandom_range(99);
         if (heap_fill == 0)
            w.slot_index = SLOT_FIELD_W'($urandom_range(HEAP_DEPTH - 1));
         else if (roll < 6 && heap_fill < HEAP_DEPTH)
            w.slot_index = SLOT_FIELD_W'($urandom_range(HEAP_DEPTH - 1, heap_fill));
         else if (roll < 10)
            w.slot_index = SLOT_FIELD_W'(heap_fill - 1);
         else if (roll < 14)
            w.slot_index = '0;
         else
            w.slot_index = SLOT_FIELD_W'($urandom_range(heap_fill - 1));
      end
      return w;
   endfunction

   task automatic offer(req_payload_type w);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (w.cmd == CMD_INSERT && heap_fill < HEAP_DEPTH)
         heap_fill++;
      @(negedge clock);
   endtask

   task automatic offer_fields(cmd_type c, int slot, int id, logic signed [KEY_FIELD_W-1:0] k);
      req_payload_type w;
      w.cmd        = c;
      w.slot_index = SLOT_FIELD_W'(slot);
      w.item_id    = ID_FIELD_W'(id);
      w.item_key   = k;
      offer(w);
   endtask

   // Leaves the block idle: every word answered, then a little slack.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0)
         @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic set_order(mode_type m);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_wdata  = ORDER_MIN;
      heap_fill  = 0;
      gap_pct    = 0;
      stall_pct  = 0;
      hold_armed = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words under the reset ordering, smallest key on top.
      offer_fields(CMD_CHANGE, 0, 3, 5);
      offer_fields(CMD_CHANGE, HEAP_DEPTH - 1, 3, 5);
      offer_fields(CMD_INSERT, 0, 0, KEY_TOP);
      offer_fields(CMD_INSERT, 0, ID_FIELD_MAX, KEY_BOT);
      offer_fields(CMD_INSERT, 0, 5, 0);
      offer_fields(CMD_INSERT, 0, 6, 0);
      offer_fields(CMD_INSERT, 0, 7, -1);
      // Same id as the one on top: it may only rise, so it stays put.
      offer_fields(CMD_CHANGE, 0, ID_FIELD_MAX, KEY_TOP);
      offer_fields(CMD_CHANGE, 0, 9, KEY_TOP);
      offer_fields(CMD_CHANGE, 4, 10, KEY_BOT);
      offer_fields(CMD_CHANGE, 5, 11, 0);
      offer_fields(CMD_INSERT, HEAP_DEPTH - 1, 512, 1);
      settle();
      set_order(ORDER_MAX);
      offer_fields(CMD_INSERT, 0, 20, KEY_TOP);
      offer_fields(CMD_CHANGE, 0, 21, KEY_BOT);
      offer_fields(CMD_CHANGE, 6, 22, KEY_TOP);
      settle();
      // With no ordering an item always climbs to the top, sinks right if it can.
      set_order(ORDER_NONE);
      offer_fields(CMD_INSERT, 0, 30, 0);
      offer_fields(CMD_CHANGE, 1, 31, 5);
      settle();
      set_order(ORDER_NONE_B);
      offer_fields(CMD_INSERT, 0, 40, -7);
      offer_fields(CMD_CHANGE, 0, 41, 3);
      settle();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         set_order(mode_plan[ph]);
         gap_pct   = gap_plan[ph % 4];
         stall_pct = stall_plan[ph % 4];
         if (ph == 4)
            hold_armed = 1'b1;
         for (int n = 0; n < PHASE_WORDS; n++)
            offer(random_word());
         settle();
      end

      $display("Checked %0d result words across min-first, max-first and unordered modes,",
               checked_count);
      $display("with the heap filled to %0d slots: %0d full and %0d out-of-range rejections.",
               heap_fill, full_count, range_count);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ibh_pkg.sv
hdl/indexed_binary_heap_unit.sv
hdl/ibh_checker.sv
verif/heap_checker.sv
verif/tb.sv
